>>> src/amac_pkg.sv
// Shared constants, types and codes of the adaptive moving average crossover block.
package amac_pkg;

  localparam int MAX_WINDOW = 63;
  localparam int RING_DEPTH = 64;
  localparam int FRAC_BITS  = 16;

  localparam int PRICE_W = 32;
  localparam int WIN_W   = 6;
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int BC_W    = $clog2(MAX_WINDOW + 2);
  localparam int VIR_W   = PRICE_W + $clog2(MAX_WINDOW + 1);
  localparam int REM_W   = VIR_W + 1;
  localparam int ER_W    = FRAC_BITS + 1;
  localparam int SC_W    = FRAC_BITS;
  localparam int P1_W    = ER_W + SC_W;
  localparam int SQ_W    = 2 * SC_W;
  localparam int WT_W    = FRAC_BITS + 1;
  localparam int STP_W   = PRICE_W + WT_W;
  localparam int SLOPE_W = PRICE_W + 1;
  localparam int ORDER_W = 3;

  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int FAST_SC_I = (4 * (1 << FRAC_BITS) + 3) / 6;
  localparam int SLOW_SC_I = (4 * (1 << FRAC_BITS) + 31) / 62;
  localparam int HALF_Q_I  = 1 << (FRAC_BITS - 1);

  localparam logic [SC_W-1:0] SLOW_SC = SC_W'(SLOW_SC_I);
  localparam logic [SC_W-1:0] SC_DIFF = SC_W'(FAST_SC_I - SLOW_SC_I);

  localparam int CFG_IW = 2;
  localparam int CFG_DW = WIN_W;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(11);

  localparam int OUT_DW = 72;
  localparam int OUT_UW = 2;

  typedef enum logic [CFG_IW-1:0] {
    REG_WINDOW = 2'd0,
    REG_TRADE  = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    SGN_FLAT = 2'd0,
    SGN_UP   = 2'd1,
    SGN_DOWN = 2'd2
  } sign_t;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_SCAN = 11'b00000000010,
    ST_DIV  = 11'b00000000100,
    ST_ERM  = 11'b00000001000,
    ST_SSC  = 11'b00000010000,
    ST_SQ   = 11'b00000100000,
    ST_WT   = 11'b00001000000,
    ST_STEP = 11'b00010000000,
    ST_UPD  = 11'b00100000000,
    ST_EMA  = 11'b01000000000,
    ST_FIN  = 11'b10000000000
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE = 4'd0,
    CMD_LOAD = 4'd1,
    CMD_SCAN = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_ERM  = 4'd4,
    CMD_SSC  = 4'd5,
    CMD_SQ   = 4'd6,
    CMD_WT   = 4'd7,
    CMD_STEP = 4'd8,
    CMD_UPD  = 4'd9,
    CMD_EMA  = 4'd10,
    CMD_FIN  = 4'd11
  } cmd_t;

  typedef struct packed {
    logic warm;
    logic scan_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> src/amac_ctrl.sv
// Sequencer stepping the datapath: scan, divide, multiply, update, EMA, output.
module amac_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  amac_pkg::sts_t  sts,
  output amac_pkg::cmd_t  cmd
);

  amac_pkg::state_t state_r, state_nxt;

  assign in_tready = (state_r == amac_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = amac_pkg::CMD_NONE;
    case (state_r)
      amac_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd       = amac_pkg::CMD_LOAD;
          state_nxt = amac_pkg::ST_SCAN;
        end
      end
      amac_pkg::ST_SCAN: begin
        if (!sts.warm) begin
          state_nxt = amac_pkg::ST_FIN;
        end else begin
          cmd = amac_pkg::CMD_SCAN;
          if (sts.scan_done) state_nxt = amac_pkg::ST_DIV;
        end
      end
      amac_pkg::ST_DIV: begin
        cmd = amac_pkg::CMD_DIV;
        if (sts.div_done) state_nxt = amac_pkg::ST_ERM;
      end
      amac_pkg::ST_ERM: begin
        cmd       = amac_pkg::CMD_ERM;
        state_nxt = amac_pkg::ST_SSC;
      end
      amac_pkg::ST_SSC: begin
        cmd       = amac_pkg::CMD_SSC;
        state_nxt = amac_pkg::ST_SQ;
      end
      amac_pkg::ST_SQ: begin
        cmd       = amac_pkg::CMD_SQ;
        state_nxt = amac_pkg::ST_WT;
      end
      amac_pkg::ST_WT: begin
        cmd       = amac_pkg::CMD_WT;
        state_nxt = amac_pkg::ST_STEP;
      end
      amac_pkg::ST_STEP: begin
        cmd       = amac_pkg::CMD_STEP;
        state_nxt = amac_pkg::ST_UPD;
      end
      amac_pkg::ST_UPD: begin
        cmd       = amac_pkg::CMD_UPD;
        state_nxt = amac_pkg::ST_EMA;
      end
      amac_pkg::ST_EMA: begin
        cmd       = amac_pkg::CMD_EMA;
        state_nxt = amac_pkg::ST_FIN;
      end
      amac_pkg::ST_FIN: begin
        if (sts.out_free) begin
          cmd       = amac_pkg::CMD_FIN;
          state_nxt = amac_pkg::ST_IDLE;
        end
      end
      default: state_nxt = amac_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= amac_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  a_load_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == amac_pkg::ST_SCAN))
    else $error("accepted transfer did not start the scan");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == amac_pkg::ST_FIN && !sts.out_free) |=> (state_r == amac_pkg::ST_FIN))
    else $error("result dropped while output register busy");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == amac_pkg::ST_DIV && !sts.div_done) |=> (state_r == amac_pkg::ST_DIV))
    else $error("divider left before its last step");

endmodule

>>> src/amac_dp.sv
// Datapath: price ring, change sum, divider, weight multiplies, averages and output register.
module amac_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  amac_pkg::cmd_t                 cmd,
  output amac_pkg::sts_t                 sts,
  input  logic [amac_pkg::PRICE_W-1:0]   in_price,
  input  logic                           cfg_we,
  input  logic [amac_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [amac_pkg::CFG_DW-1:0]    cfg_data,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [amac_pkg::OUT_DW-1:0]    out_tdata,
  output logic [amac_pkg::OUT_UW-1:0]    out_tuser
);

  localparam int PW = amac_pkg::PRICE_W;
  localparam int F  = amac_pkg::FRAC_BITS;

  logic [PW-1:0] ring [amac_pkg::RING_DEPTH];

  logic [amac_pkg::RING_AW-1:0] ptr_r, cur_r, rd_addr;
  logic [amac_pkg::BC_W-1:0]    bc_r, bc_nxt, k_r, win_eff;
  logic [amac_pkg::WIN_W-1:0]   win_r;
  logic                         trade_r, warm_r, iss_v_r, iss_last_r;
  logic [PW-1:0]                price_r, rd_r, prev_px_r, avg_r, ema_r, prevavg_r;
  logic [amac_pkg::VIR_W-1:0]   vir_r;
  logic [amac_pkg::REM_W-1:0]   rem_r, div_r, div_sub;
  logic                         div_ge;
  logic [amac_pkg::ER_W-1:0]    q_r, er;
  logic [amac_pkg::DCNT_W-1:0]  dcnt_r;
  logic [amac_pkg::P1_W-1:0]    p1_r;
  logic [amac_pkg::P1_W:0]      p1_rnd;
  logic [amac_pkg::SC_W-1:0]    ssc_r;
  logic [amac_pkg::SQ_W-1:0]    sq_r;
  logic [amac_pkg::SQ_W:0]      sq_rnd;
  logic [amac_pkg::WT_W-1:0]    wt_r;
  logic [amac_pkg::STP_W-1:0]   stp_r;
  logic [amac_pkg::STP_W:0]     stp_rnd;
  logic [PW-1:0]                mag, step, adiff_scan, adiff_dir, s1;
  logic                         loaded_r, ready_r;
  logic [1:0]                   ecnt_r;
  amac_pkg::sign_t              pss_r, sgn;
  logic [amac_pkg::SLOPE_W-1:0] sl;
  logic [amac_pkg::ORDER_W-1:0] order;
  logic                         out_v_r;
  logic [PW-1:0]                o_avg_r;
  logic                         o_ready_r, o_sv_r;
  logic [amac_pkg::SLOPE_W-1:0] o_slope_r;
  logic [amac_pkg::ORDER_W-1:0] o_order_r;

  always_comb begin
    if (win_r == '0)
      win_eff = amac_pkg::BC_W'(1);
    else if (amac_pkg::BC_W'(win_r) > amac_pkg::BC_W'(amac_pkg::MAX_WINDOW))
      win_eff = amac_pkg::BC_W'(amac_pkg::MAX_WINDOW);
    else
      win_eff = amac_pkg::BC_W'(win_r);
  end

  assign bc_nxt = (bc_r < amac_pkg::BC_W'(amac_pkg::MAX_WINDOW + 1)) ? bc_r + 1'b1 : bc_r;
  assign rd_addr = cur_r - k_r[amac_pkg::RING_AW-1:0];

  assign adiff_scan = (prev_px_r >= rd_r) ? prev_px_r - rd_r : rd_r - prev_px_r;
  assign adiff_dir  = (price_r >= rd_r) ? price_r - rd_r : rd_r - price_r;

  assign div_r   = (dcnt_r == '0) ? rem_r : {rem_r[amac_pkg::REM_W-2:0], 1'b0};
  assign div_ge  = (div_r >= {1'b0, vir_r});
  assign div_sub = div_r - {1'b0, vir_r};
  assign er      = (vir_r == '0) ? '0 : q_r;

  assign p1_rnd  = {1'b0, p1_r} + (amac_pkg::P1_W + 1)'(amac_pkg::HALF_Q_I);
  assign sq_rnd  = {1'b0, sq_r} + (amac_pkg::SQ_W + 1)'(amac_pkg::HALF_Q_I);
  assign stp_rnd = {1'b0, stp_r} + (amac_pkg::STP_W + 1)'(amac_pkg::HALF_Q_I);
  assign mag     = (price_r >= avg_r) ? price_r - avg_r : avg_r - price_r;
  assign step    = stp_rnd[F +: PW];

  assign s1 = ready_r ? ema_r : '0;
  assign sl = {1'b0, s1} - {1'b0, prevavg_r};

  always_comb begin
    if (sl == '0)                     sgn = amac_pkg::SGN_FLAT;
    else if (sl[amac_pkg::SLOPE_W-1]) sgn = amac_pkg::SGN_DOWN;
    else                              sgn = amac_pkg::SGN_UP;
    order = '0;
    if (trade_r) begin
      case (sgn)
        amac_pkg::SGN_UP: begin
          if (pss_r == amac_pkg::SGN_FLAT)      order = amac_pkg::ORDER_W'(1);
          else if (pss_r == amac_pkg::SGN_DOWN) order = amac_pkg::ORDER_W'(2);
        end
        amac_pkg::SGN_DOWN: begin
          if (pss_r == amac_pkg::SGN_FLAT)    order = '1;
          else if (pss_r == amac_pkg::SGN_UP) order = {{(amac_pkg::ORDER_W-1){1'b1}}, 1'b0};
        end
        default: order = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == amac_pkg::CMD_LOAD) ring[ptr_r] <= in_price;
    rd_r <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      bc_r      <= '0;
      win_r     <= amac_pkg::WIN_RESET;
      trade_r   <= 1'b0;
      warm_r    <= 1'b0;
      iss_v_r   <= 1'b0;
      iss_last_r<= 1'b0;
      k_r       <= '0;
      dcnt_r    <= '0;
      avg_r     <= '0;
      loaded_r  <= 1'b0;
      ema_r     <= '0;
      ecnt_r    <= '0;
      ready_r   <= 1'b0;
      prevavg_r <= '0;
      pss_r     <= amac_pkg::SGN_FLAT;
      vir_r     <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (out_v_r && out_tready && cmd != amac_pkg::CMD_FIN) out_v_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          amac_pkg::REG_WINDOW: win_r <= cfg_data;
          amac_pkg::REG_TRADE: begin
            trade_r   <= cfg_data[0];
            prevavg_r <= '0;
            pss_r     <= amac_pkg::SGN_FLAT;
          end
          default: ;
        endcase
      end
      case (cmd)
        amac_pkg::CMD_LOAD: begin
          price_r   <= in_price;
          prev_px_r <= in_price;
          cur_r     <= ptr_r;
          ptr_r     <= ptr_r + 1'b1;
          bc_r      <= bc_nxt;
          warm_r    <= (bc_nxt > win_eff);
          k_r       <= amac_pkg::BC_W'(1);
          iss_v_r   <= 1'b0;
          iss_last_r<= 1'b0;
          vir_r     <= '0;
          ready_r   <= 1'b0;
        end
        amac_pkg::CMD_SCAN: begin
          if (k_r <= win_eff) begin
            iss_v_r    <= 1'b1;
            iss_last_r <= (k_r == win_eff);
            k_r        <= k_r + 1'b1;
          end else begin
            iss_v_r <= 1'b0;
          end
          if (iss_v_r) begin
            vir_r     <= vir_r + amac_pkg::VIR_W'(adiff_scan);
            prev_px_r <= rd_r;
            if (iss_last_r) begin
              rem_r  <= amac_pkg::REM_W'(adiff_dir);
              q_r    <= '0;
              dcnt_r <= '0;
            end
          end
        end
        amac_pkg::CMD_DIV: begin
          q_r    <= {q_r[amac_pkg::ER_W-2:0], div_ge};
          rem_r  <= div_ge ? div_sub : div_r;
          dcnt_r <= dcnt_r + 1'b1;
        end
        amac_pkg::CMD_ERM: p1_r  <= amac_pkg::P1_W'(er) * amac_pkg::P1_W'(amac_pkg::SC_DIFF);
        amac_pkg::CMD_SSC: ssc_r <= amac_pkg::SLOW_SC + p1_rnd[F +: amac_pkg::SC_W];
        amac_pkg::CMD_SQ:  sq_r  <= amac_pkg::SQ_W'(ssc_r) * amac_pkg::SQ_W'(ssc_r);
        amac_pkg::CMD_WT:  wt_r  <= sq_rnd[F +: amac_pkg::WT_W];
        amac_pkg::CMD_STEP: stp_r <= amac_pkg::STP_W'(mag) * amac_pkg::STP_W'(wt_r);
        amac_pkg::CMD_UPD: begin
          if (!loaded_r) begin
            avg_r    <= price_r;
            loaded_r <= 1'b1;
          end else if (price_r >= avg_r) begin
            avg_r <= avg_r + step;
          end else begin
            avg_r <= avg_r - step;
          end
        end
        amac_pkg::CMD_EMA: begin
          if (ecnt_r == 2'd0) begin
            ema_r  <= avg_r;
            ecnt_r <= 2'd1;
          end else begin
            ema_r <= PW'(({1'b0, ema_r} + {1'b0, avg_r} + 1'b1) >> 1);
            if (ecnt_r == 2'd3) ready_r <= 1'b1;
            else                ecnt_r  <= ecnt_r + 1'b1;
          end
        end
        amac_pkg::CMD_FIN: begin
          out_v_r   <= 1'b1;
          o_avg_r   <= s1;
          o_ready_r <= ready_r;
          prevavg_r <= s1;
          if (prevavg_r == '0) begin
            o_sv_r    <= 1'b0;
            o_slope_r <= '0;
            o_order_r <= '0;
          end else begin
            o_sv_r    <= 1'b1;
            o_slope_r <= sl;
            o_order_r <= order;
            pss_r     <= sgn;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.warm      = warm_r;
  assign sts.scan_done = iss_v_r && iss_last_r;
  assign sts.div_done  = (dcnt_r == amac_pkg::DCNT_W'(amac_pkg::DIV_STEPS - 1));
  assign sts.out_free  = !out_v_r || out_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(amac_pkg::OUT_DW - PW - amac_pkg::SLOPE_W - amac_pkg::ORDER_W){1'b0}},
                       o_order_r, o_slope_r, o_avg_r};
  assign out_tuser  = {o_sv_r, o_ready_r};

endmodule

>>> src/adaptive_moving_average_crossover.sv
// Top level of the adaptive moving average crossover block.
// The result reaches out_tvalid after the ring scan (one entry a cycle) and the 17-step
// divider once the window is full; during warm-up both are skipped. One item at a time:
// in_tready comes back high with out_tvalid; an output stall holds the next result back.
// Synchronous active-low reset clears control state, sets window_length to 11; ring kept.
module adaptive_moving_average_crossover (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] bar price
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] smoothed_average, [64:32] slope, [67:65] order
  output logic [1:0]  out_tuser,  // [0] average_ready, [1] slope_valid
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  amac_pkg::cmd_t cmd;
  amac_pkg::sts_t sts;

  amac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  amac_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_price   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
